// File: design/nmad_pkg.sv
// Shared types, constants and edge functions for the neighbour max-abs-diff edge core.
package nmad_pkg;

    localparam int PIX_W      = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix pixel_above;
        t_pix pixel_centre;
        t_pix pixel_below;
        logic row_first;
        logic row_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       end_of_row;
    } t_out_word;

    typedef struct packed {
        t_pix up;
        t_pix mid;
        t_pix down;
    } t_column;

    typedef struct packed {
        logic      a_valid;
        t_out_word a;
        logic      b_valid;
        t_out_word b;
    } t_push;

    function automatic t_pix absdiff(input t_pix x, input t_pix y);
        return (x > y) ? t_pix'(x - y) : t_pix'(y - x);
    endfunction

    function automatic t_pix max2(input t_pix x, input t_pix y);
        return (x > y) ? x : y;
    endfunction

    function automatic t_pix col_max(input t_column c, input t_pix centre);
        return max2(max2(absdiff(c.up, centre), absdiff(c.mid, centre)),
                    absdiff(c.down, centre));
    endfunction

    // self column always counts; left and right only when present
    function automatic logic [7:0] edge_of(input t_column self, input t_column left,
                                           input logic use_left, input t_column right,
                                           input logic use_right);
        t_pix acc;
        t_pix dl;
        t_pix dr;
        acc = col_max(self, self.mid);
        dl  = use_left  ? col_max(left, self.mid)  : '0;
        dr  = use_right ? col_max(right, self.mid) : '0;
        acc = max2(acc, max2(dl, dr));
        return 8'(acc);
    endfunction

endpackage

// File: design/nmad_column_unit.sv
// Column history and per-column edge computation, up to two result words per column.
module nmad_column_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nmad_pkg::t_in_word i_word,
    input  logic              i_advance,
    output logic [1:0]        o_need,
    output nmad_pkg::t_push   o_push
);
    import nmad_pkg::*;

    t_column   r_prev;
    t_column   r_old;
    logic [1:0] r_seen;

    t_column   cur;
    logic [1:0] seen;
    logic      has_prev;
    logic      has_old;

    assign cur.up   = i_word.pixel_above;
    assign cur.mid  = i_word.pixel_centre;
    assign cur.down = i_word.pixel_below;

    assign seen     = i_word.row_first ? SEEN_NONE : r_seen;
    assign has_prev = (seen != SEEN_NONE);
    assign has_old  = (seen == SEEN_TWO);

    assign o_need = {1'b0, has_prev} + {1'b0, i_word.row_last};

    always_comb begin
        o_push.a_valid      = i_advance && has_prev;
        o_push.a.edge_value = edge_of(r_prev, r_old, has_old, cur, 1'b1);
        o_push.a.end_of_row = 1'b0;
        o_push.b_valid      = i_advance && i_word.row_last;
        o_push.b.edge_value = edge_of(cur, r_prev, has_prev, cur, 1'b0);
        o_push.b.end_of_row = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
        end else if (i_advance) begin
            if (i_word.row_last) begin
                r_seen <= SEEN_NONE;
            end else begin
                r_seen <= has_old ? SEEN_TWO : 2'(seen + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && !i_word.row_last) begin
            r_old  <= r_prev;
            r_prev <= cur;
        end
    end

endmodule

// File: design/nmad_result_fifo.sv
// Small result queue taking up to two words per cycle and giving one.
module nmad_result_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nmad_pkg::t_push              i_push,
    input  logic                         i_pop,
    output logic [nmad_pkg::CNT_W-1:0]   o_count,
    output nmad_pkg::t_out_word          o_word
);
    import nmad_pkg::*;

    t_out_word          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic [1:0]         npush;
    logic [FIFO_AW-1:0] b_idx;
    logic [CNT_W:0]     n_count_wide;

    assign npush  = {1'b0, i_push.a_valid} + {1'b0, i_push.b_valid};
    assign b_idx  = r_wr_ptr + FIFO_AW'(i_push.a_valid);
    assign n_count_wide = (CNT_W+1)'(r_count) + (CNT_W+1)'(npush) - (CNT_W+1)'(i_pop);

    assign o_count = r_count;
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[b_idx] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(npush);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(i_pop);
            r_count  <= CNT_W'(n_count_wide);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_count_wide <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty result queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FIFO_AW'(r_wr_ptr - r_rd_ptr) == FIFO_AW'(r_count))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: design/neighbour_max_abs_diff_edge_core.sv
// Top level: input register, column unit and result queue of the 3x3 max-abs-diff edge core.
// With an empty queue a column's word is offered once the next column of its row has passed
// the input register into the queue; the rightmost column's own word is queued behind it.
// Throughput: one column per cycle while the four-word queue has room; a rightmost column
// yields two words, so the single output port, when not stalled, sets one word per cycle.
// Reset clears the input valid flag, the held-column count and the queue pointers.
module neighbour_max_abs_diff_edge_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  nmad_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output nmad_pkg::t_out_word o_word
);
    import nmad_pkg::*;

    t_in_word         r_in;
    logic             r_in_valid;

    logic [1:0]       need;
    t_push            push;
    logic [CNT_W-1:0] count;
    logic             pop;
    logic             advance;
    logic             accept;

    assign o_valid = (count != '0);
    assign pop     = o_valid && !i_stall;
    assign advance = r_in_valid &&
                     ((CNT_W+1)'(count) + (CNT_W+1)'(need) <=
                      (CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop));
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_word;
        end
    end

    nmad_column_unit u_column (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (r_in),
        .i_advance (advance),
        .o_need    (need),
        .o_push    (push)
    );

    nmad_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_count (count),
        .o_word  (o_word)
    );

endmodule
